// ----- hw/rtl/irt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and codes of the interval reservation table: request kinds,
// result status codes, the stored interval and the cell chain controls.
// ----------------------------------------------------------------------------
package irt_pkg;

  // minutes in one day, upper bound for a booked start
  localparam int unsigned MINUTES_PER_DAY = 24 * 60;

  // field widths
  localparam int unsigned StartW  = 11;
  localparam int unsigned LengthW = 11;
  localparam int unsigned EndW    = 12;
  localparam int unsigned CfgW    = 11;

  // configuration register indexes
  localparam logic CFG_MIN_DURATION = 1'b0;
  localparam logic CFG_MAX_DURATION = 1'b1;

  // request kinds
  typedef enum logic [1:0] {
    REQ_BOOK   = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_LIST   = 2'd2
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERLAP  = 3'd1,
    ST_BAD      = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  // one stored interval
  typedef struct packed {
    logic [EndW-1:0]   end_min;
    logic [StartW-1:0] start_min;
  } entry_t;

  // operation applied to every cell in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  // per-cell compare results against the current request
  typedef struct packed {
    logic lt;       // occupied and stored start below request start
    logic match;    // occupied and stored start equals request start
    logic overlap;  // occupied and stored interval overlaps request
  } cell_flags_t;

endpackage : irt_pkg
`default_nettype wire

// ----- hw/rtl/interval_reservation_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// interval_reservation_table
// Ordered table of booked intervals of one day with overlap check.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the request kind,
// tdata the start minute and length. Results leave on m_axis: tuser carries
// the status, tdata the entry start and end, tlast marks the final result
// of a request. The cfg port writes the duration bounds at any edge.
// Book and cancel are accepted at once: all cells compare against the
// request at once and the chain shifts in the same cycle, so the result is
// in the output register in the cycle after the request. During a list,
// the chain rotates one slot per cycle while results are taken, and the
// head cell feeds the output register; no request is taken meanwhile.
// A new request is taken while a result is taken in the same cycle.
// When the receiver stalls, the output register holds and s_axis_tready
// drops until the result leaves. Reset empties the table and loads the
// bounds 15 and 60; slot contents are not cleared.
// ----------------------------------------------------------------------------
module interval_reservation_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // start_minute[10:0], length_minutes[21:11]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // entry_start[10:0], entry_end[22:11]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  output logic        m_axis_tlast,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i
);
  import irt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  entry_t            out_entry_q, out_entry_d;
  logic              out_last_q, out_last_d;
  logic [CfgW-1:0]   min_q;
  logic [CfgW-1:0]   max_q;

  logic              in_acc;
  logic              out_free;
  req_e              req;
  logic [LengthW-1:0] len;
  entry_t            req_entry;
  cell_op_e          cell_op;
  logic [TABLE_ENTRIES-1:0] occ;
  entry_t            cell_data [TABLE_ENTRIES];
  cell_flags_t       cell_flags [TABLE_ENTRIES];
  logic              ovl_any;
  logic              found;
  logic [EndW-1:0]   found_end;
  logic              bad_dur;
  logic              full;
  logic              book_ok;
  status_e           book_status;

  // request decode
  assign req                 = req_e'(s_axis_tuser);
  assign req_entry.start_min = s_axis_tdata[StartW-1:0];
  assign len                 = s_axis_tdata[StartW+LengthW-1:StartW];
  assign req_entry.end_min   = {1'b0, req_entry.start_min} + {1'b0, len};

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // chain of cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t left_data;
    entry_t right_data;
    logic   left_lt;
    logic   next_occ;

    assign occ[i] = CntW'(i) < count_q;

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_lt   = 1'b1;
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
      assign left_lt   = cell_flags[i-1].lt;
    end

    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign right_data = '0;
      assign next_occ   = 1'b0;
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
      assign next_occ   = CntW'(i + 1) < count_q;
    end

    irt_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (cell_op),
      .req_i      (req_entry),
      .occ_i      (occ[i]),
      .next_occ_i (next_occ),
      .left_lt_i  (left_lt),
      .left_i     (left_data),
      .right_i    (right_data),
      .head_i     (cell_data[0]),
      .data_o     (cell_data[i]),
      .flags_o    (cell_flags[i])
    );
  end

  // reduce cell flags and pick the matched entry
  always_comb begin
    ovl_any   = 1'b0;
    found     = 1'b0;
    found_end = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      ovl_any   = ovl_any | cell_flags[i].overlap;
      found     = found | cell_flags[i].match;
      found_end = found_end | (cell_flags[i].match ? cell_data[i].end_min : '0);
    end
  end

  // book checks in priority order
  assign bad_dur = ({2'b00, req_entry.start_min} >= 13'(MINUTES_PER_DAY)) ||
                   (len < min_q) || (len > max_q);
  assign full    = count_q == CntW'(TABLE_ENTRIES);

  always_comb begin
    if (bad_dur) begin
      book_status = ST_BAD;
    end else if (ovl_any) begin
      book_status = ST_OVERLAP;
    end else if (full) begin
      book_status = ST_FULL;
    end else begin
      book_status = ST_OK;
    end
  end

  assign book_ok = book_status == ST_OK;

  // control and output register next state
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    cell_op      = CELL_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req)
            REQ_BOOK: begin
              out_valid_d  = 1'b1;
              out_status_d = book_status;
              out_entry_d  = req_entry;
              out_last_d   = 1'b1;
              if (book_ok) begin
                cell_op = CELL_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            REQ_CANCEL: begin
              out_valid_d           = 1'b1;
              out_entry_d.start_min = req_entry.start_min;
              out_last_d            = 1'b1;
              if (found) begin
                out_status_d        = ST_OK;
                out_entry_d.end_min = found_end;
                cell_op             = CELL_REMOVE;
                count_d             = count_q - 1'b1;
              end else begin
                out_status_d        = ST_NOTFOUND;
                out_entry_d.end_min = '0;
              end
            end
            REQ_LIST: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_EMPTY;
                out_entry_d  = '0;
                out_last_d   = 1'b1;
              end else begin
                state_d = S_LIST;
                idx_d   = '0;
              end
            end
            default: begin
              out_valid_d = out_valid_q && !m_axis_tready;
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_entry_d  = cell_data[0];
          out_last_d   = idx_q == (count_q - 1'b1);
          cell_op      = CELL_ROTATE;
          idx_d        = idx_q + 1'b1;
          if (idx_q == (count_q - 1'b1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_entry_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_entry_q  <= out_entry_d;
      out_last_q   <= out_last_d;
    end
  end

  // duration bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= CfgW'(15);
      max_q <= CfgW'(60);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_DURATION: min_q <= cfg_data_i;
        CFG_MAX_DURATION: max_q <= cfg_data_i;
        default: min_q <= min_q;
      endcase
    end
  end

  // result channel
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_entry_q.end_min, out_entry_q.start_min};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_ENTRIES))
    else $error("entry count above table size");

  // no request is taken while a list streams
  a_list_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> !s_axis_tready)
    else $error("request taken during list");

  // a successful book grows the table by one
  a_book_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (req == REQ_BOOK) && book_ok) |=> (count_q == $past(count_q) + 1'b1))
    else $error("book did not insert");

  // the last listed entry ends the list
  a_list_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_LIST) && out_free && (idx_q == (count_q - 1'b1)))
      |=> (state_q == S_IDLE) && m_axis_tlast && m_axis_tvalid)
    else $error("list did not end on its last entry");
`endif

endmodule : interval_reservation_table
`default_nettype wire

// ----- hw/rtl/irt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irt_cell
// One slot of the ordered interval chain. Compares its interval with the
// current request and takes its next value from itself, the request, its
// left or right neighbor or the head of the chain.
// ----------------------------------------------------------------------------
module irt_cell (
  input  logic                 clk_i,
  input  irt_pkg::cell_op_e    op_i,
  input  irt_pkg::entry_t      req_i,
  input  logic                 occ_i,
  input  logic                 next_occ_i,
  input  logic                 left_lt_i,
  input  irt_pkg::entry_t      left_i,
  input  irt_pkg::entry_t      right_i,
  input  irt_pkg::entry_t      head_i,
  output irt_pkg::entry_t      data_o,
  output irt_pkg::cell_flags_t flags_o
);
  import irt_pkg::*;

  entry_t      data_q;
  entry_t      data_d;
  logic [EndW-1:0] s_ext;
  logic [EndW-1:0] cs_ext;
  logic        ovl_raw;

  // compares against the request interval
  assign s_ext  = {1'b0, req_i.start_min};
  assign cs_ext = {1'b0, data_q.start_min};
  assign ovl_raw = ((s_ext >= cs_ext) && (s_ext < data_q.end_min)) ||
                   ((req_i.end_min > cs_ext) && (req_i.end_min <= data_q.end_min)) ||
                   ((s_ext <= cs_ext) && (req_i.end_min >= data_q.end_min));

  assign flags_o.lt      = occ_i && (data_q.start_min < req_i.start_min);
  assign flags_o.match   = occ_i && (data_q.start_min == req_i.start_min);
  assign flags_o.overlap = occ_i && ovl_raw;

  // next value selection
  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_INSERT: begin
        if (flags_o.lt) begin
          data_d = data_q;
        end else if (left_lt_i) begin
          data_d = req_i;
        end else begin
          data_d = left_i;
        end
      end
      CELL_REMOVE: begin
        if (!flags_o.lt) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        data_d = next_occ_i ? right_i : head_i;
      end
      default: data_d = data_q;
    endcase
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule : irt_cell
`default_nettype wire

// ----- dv/tb_interval_reservation_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interval_reservation_table
// Self-checking bench for the interval reservation table. A short table of
// directed requests covers the duration bounds, overlap edges, out-of-day
// starts and the empty table. Random book, cancel and list traffic then runs
// under several bound settings, including a pass that fills the table up.
// Every accepted request goes through a behavioral model of the table.
// Results are compared in order against the expected results, from the model or a directed row's typed answer.
// ----------------------------------------------------------------------------
module tb_interval_reservation_table;
  import irt_pkg::*;

  localparam int TableDepth   = 16;
  localparam int SettleCycles = 4;
  localparam int CycleLimit   = 500000;
  localparam int FieldMax     = 2047;

  // request kind the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    status_e     status;
    logic [10:0] entry_start;
    logic [11:0] entry_end;
    logic        last;
  } slot_result_t;

  typedef struct {
    logic [1:0]   kind;
    logic [10:0]  start_min;
    logic [10:0]  length_min;
    logic         typed;
    slot_result_t answer;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // start_minute[10:0], length_minutes[21:11]
  logic [1:0]  s_axis_tuser;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // entry_start[10:0], entry_end[22:11]
  logic [2:0]  m_axis_tuser;   // status[2:0]
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [10:0] cfg_data_i;

  // shadow of the table contents and duration bounds
  logic [10:0]  booked_start [TableDepth];
  logic [11:0]  booked_end   [TableDepth];
  int           booked_count;
  int           bound_lo;
  int           bound_hi;

  slot_result_t expected_q [$];
  slot_result_t fresh_q [$];
  dir_row_t     dir_rows [$];

  // typed answer riding along with the request on the bus
  logic         row_typed;
  slot_result_t row_expect;

  int mismatches;
  int results_seen;
  int cycle_count;
  int send_calm;
  int hold_left;
  int calm_left;
  bit pressure_done;

  interval_reservation_table #(
    .TABLE_ENTRIES (TableDepth)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic slot_result_t result_of(input status_e st, input int s, input int e,
                                             input logic last);
    slot_result_t r;
    r.status      = st;
    r.entry_start = s[10:0];
    r.entry_end   = e[11:0];
    r.last        = last;
    return r;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // table behavior: fills fresh_q with the results of one request
  task automatic predict_outcome(input logic [1:0] kind, input logic [10:0] st,
                                 input logic [10:0] len);
    int      s, e, i, pos, hit;
    status_e verdict;
    s = int'(st);
    e = int'(st) + int'(len);
    case (kind)
      REQ_BOOK: begin
        if (s >= MINUTES_PER_DAY || len < bound_lo || len > bound_hi) begin
          verdict = ST_BAD;
        end else begin
          verdict = ST_OK;
          for (i = 0; i < booked_count; i++) begin
            if ((s >= booked_start[i] && s < booked_end[i]) ||
                (e > booked_start[i] && e <= booked_end[i]) ||
                (s <= booked_start[i] && e >= booked_end[i]))
              verdict = ST_OVERLAP;
          end
          if (verdict == ST_OK && booked_count >= TableDepth) verdict = ST_FULL;
        end
        // insert in start order
        if (verdict == ST_OK) begin
          pos = 0;
          while (pos < booked_count && booked_start[pos] < st) pos++;
          for (i = booked_count; i > pos; i--) begin
            booked_start[i] = booked_start[i-1];
            booked_end[i]   = booked_end[i-1];
          end
          booked_start[pos] = st;
          booked_end[pos]   = e[11:0];
          booked_count++;
        end
        fresh_q.push_back(result_of(verdict, s, e, 1'b1));
      end
      REQ_CANCEL: begin
        hit = -1;
        for (i = 0; i < booked_count; i++) begin
          if (hit < 0 && booked_start[i] == st) hit = i;
        end
        if (hit < 0) begin
          fresh_q.push_back(result_of(ST_NOTFOUND, s, 0, 1'b1));
        end else begin
          fresh_q.push_back(result_of(ST_OK, int'(booked_start[hit]), int'(booked_end[hit]),
                                      1'b1));
          for (i = hit; i + 1 < booked_count; i++) begin
            booked_start[i] = booked_start[i+1];
            booked_end[i]   = booked_end[i+1];
          end
          booked_count--;
        end
      end
      REQ_LIST: begin
        if (booked_count == 0) fresh_q.push_back(result_of(ST_EMPTY, 0, 0, 1'b1));
        for (i = 0; i < booked_count; i++)
          fresh_q.push_back(result_of(ST_OK, int'(booked_start[i]), int'(booked_end[i]),
                                      i + 1 == booked_count));
      end
      default: ;
    endcase
  endtask

  // result check and request capture, both at the rising edge
  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status %0d start %0d end %0d last %0b",
                                  m_axis_tuser, m_axis_tdata[10:0], m_axis_tdata[22:11],
                                  m_axis_tlast));
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tuser !== want.status || m_axis_tdata[10:0] !== want.entry_start ||
              m_axis_tdata[22:11] !== want.entry_end || m_axis_tlast !== want.last)
            flag_mismatch($sformatf(
              "exp st %0d start %0d end %0d last %0b, got st %0d start %0d end %0d last %0b",
              want.status, want.entry_start, want.entry_end, want.last, m_axis_tuser,
              m_axis_tdata[10:0], m_axis_tdata[22:11], m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fresh_q.delete();
        predict_outcome(s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[21:11]);
        if (row_typed) begin
          expected_q.push_back(row_expect);
        end else begin
          foreach (fresh_q[k]) expected_q.push_back(fresh_q[k]);
        end
      end
    end
  end

  // gap length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // result side: random stalls, calm stretches, one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!pressure_done && results_seen >= 40) begin
        pressure_done = 1'b1;
        hold_left     = 180;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        m_axis_tready = 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        calm_left     = $urandom_range(20, 60);
        m_axis_tready = 1'b1;
      end else if ($urandom_range(0, 2) != 0) begin
        m_axis_tready = 1'b1;
      end else begin
        hold_left     = gap_len() - 1;
        m_axis_tready = 1'b0;
      end
    end
  end

  // drive one request from a falling edge, return at the falling edge after it is taken
  task automatic send_req(input logic [1:0] kind, input logic [10:0] st,
                          input logic [10:0] len, input logic typed, input slot_result_t ans);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else if ($urandom_range(0, 29) == 0) begin
      send_calm = $urandom_range(20, 50);
      gap       = 0;
    end else begin
      gap = $urandom_range(0, 1) ? gap_len() : 0;
    end
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = kind;
    s_axis_tdata  = {2'b00, len, st};
    row_typed     = typed;
    row_expect    = ans;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_plain(input logic [1:0] kind, input logic [10:0] st,
                            input logic [10:0] len);
    send_req(kind, st, len, 1'b0, result_of(ST_OK, 0, 0, 1'b0));
  endtask

  // wait for every expected result, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_bounds(input int lo, input int hi);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_MIN_DURATION;
    cfg_data_i = lo[10:0];
    @(negedge clk_i);
    cfg_idx_i  = CFG_MAX_DURATION;
    cfg_data_i = hi[10:0];
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    bound_lo   = lo;
    bound_hi   = hi;
  endtask

  // starts cluster around stored edges to hit the overlap corners
  function automatic logic [10:0] pick_start();
    int r, k, v;
    r = $urandom_range(0, 99);
    if (r < 40 && booked_count > 0) begin
      k = $urandom_range(0, booked_count - 1);
      v = $urandom_range(0, 4);
      v = v - 2 + ($urandom_range(0, 1) ? int'(booked_end[k]) : int'(booked_start[k]));
      if (v < 0) v = 0;
      if (v > FieldMax) v = FieldMax;
      return v[10:0];
    end
    if (r < 80) return 11'($urandom_range(0, MINUTES_PER_DAY - 1));
    if (r < 90) return 11'($urandom_range(MINUTES_PER_DAY, FieldMax));
    return 11'($urandom_range(0, FieldMax));
  endfunction

  // lengths mostly legal and short, with the bounds and just past them
  function automatic logic [10:0] pick_length();
    int r, top;
    r = $urandom_range(0, 99);
    top = (bound_hi < bound_lo + 90) ? bound_hi : bound_lo + 90;
    if (bound_lo <= bound_hi && r < 45) return 11'($urandom_range(bound_lo, top));
    if (bound_lo <= bound_hi && r < 70) return 11'($urandom_range(bound_lo, bound_hi));
    if (r < 75) return 11'(bound_lo);
    if (r < 80) return 11'(bound_hi);
    if (r < 85) return (bound_lo > 0) ? 11'(bound_lo - 1) : 11'(bound_lo);
    if (r < 90) return (bound_hi < FieldMax) ? 11'(bound_hi + 1) : 11'(bound_hi);
    return 11'($urandom_range(0, FieldMax));
  endfunction

  task automatic random_request();
    int r;
    logic [10:0] st;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_plain(REQ_BOOK, pick_start(), pick_length());
    end else if (r < 78) begin
      if (booked_count > 0 && $urandom_range(0, 9) < 7)
        st = booked_start[$urandom_range(0, booked_count - 1)];
      else
        st = 11'($urandom_range(0, FieldMax));
      send_plain(REQ_CANCEL, st, 11'($urandom_range(0, FieldMax)));
    end else if (r < 95) begin
      send_plain(REQ_LIST, 11'($urandom_range(0, FieldMax)), 11'($urandom_range(0, FieldMax)));
    end else begin
      send_plain(REQ_UNUSED, 11'($urandom_range(0, FieldMax)),
                 11'($urandom_range(0, FieldMax)));
    end
  endtask

  task automatic random_batch(input int n);
    repeat (n) random_request();
  endtask

  // clear the table, book it full, overflow it, then list, cancel, book one more and list again
  task automatic fill_table();
    int n;
    n = 0;
    while (booked_count > 0) send_plain(REQ_CANCEL, booked_start[0], 0);
    while (booked_count < TableDepth && n < 80) begin
      send_plain(REQ_BOOK, 11'($urandom_range(0, MINUTES_PER_DAY - 1)),
                 11'($urandom_range(0, 12)));
      n++;
    end
    repeat (3) send_plain(REQ_BOOK, 11'($urandom_range(0, MINUTES_PER_DAY - 1)), 1);
    send_plain(REQ_LIST, 0, 0);
    repeat (3) send_plain(REQ_CANCEL, booked_start[$urandom_range(0, booked_count - 1)], 0);
    send_plain(REQ_BOOK, 11'($urandom_range(0, MINUTES_PER_DAY - 1)), 5);
    send_plain(REQ_LIST, 0, 0);
  endtask

  function automatic void add_row(input logic [1:0] kind, input int st, input int len,
                                  input logic typed, input status_e status,
                                  input int es, input int ee);
    dir_row_t row;
    row.kind       = kind;
    row.start_min  = st[10:0];
    row.length_min = len[10:0];
    row.typed      = typed;
    row.answer     = result_of(status, es, ee, 1'b1);
    dir_rows.push_back(row);
  endfunction

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MIN_DURATION;
    cfg_data_i    = '0;
    row_typed     = 1'b0;
    row_expect    = result_of(ST_OK, 0, 0, 1'b0);
    booked_count  = 0;
    bound_lo      = 15;
    bound_hi      = 60;
    mismatches    = 0;
    results_seen  = 0;
    cycle_count   = 0;
    send_calm     = 0;
    hold_left     = 0;
    calm_left     = 0;
    pressure_done = 1'b0;
    foreach (booked_start[i]) begin
      booked_start[i] = '0;
      booked_end[i]   = '0;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, reset bounds 15..60
    add_row(REQ_LIST,   0,    0,    1, ST_EMPTY,    0,    0);     // list of empty table
    add_row(REQ_CANCEL, 100,  0,    1, ST_NOTFOUND, 100,  0);
    add_row(REQ_BOOK,   0,    15,   1, ST_OK,       0,    15);    // shortest, first minute
    add_row(REQ_BOOK,   1380, 60,   1, ST_OK,       1380, 1440);  // longest, ends at midnight
    add_row(REQ_BOOK,   500,  14,   1, ST_BAD,      500,  514);
    add_row(REQ_BOOK,   500,  61,   1, ST_BAD,      500,  561);
    add_row(REQ_BOOK,   1439, 30,   1, ST_OVERLAP,  1439, 1469);  // passes midnight
    add_row(REQ_BOOK,   1440, 30,   1, ST_BAD,      1440, 1470);  // start out of day
    add_row(REQ_BOOK,   2047, 2047, 1, ST_BAD,      2047, 4094);
    add_row(REQ_BOOK,   5,    20,   1, ST_OVERLAP,  5,    25);
    add_row(REQ_BOOK,   15,   15,   1, ST_OK,       15,   30);    // touches, no overlap
    add_row(REQ_BOOK,   1370, 20,   1, ST_OVERLAP,  1370, 1390);
    add_row(REQ_BOOK,   600,  40,   1, ST_OK,       600,  640);
    add_row(REQ_BOOK,   590,  60,   1, ST_OVERLAP,  590,  650);   // covers stored entry
    add_row(REQ_LIST,   0,    0,    0, ST_OK,       0,    0);
    add_row(REQ_UNUSED, 2047, 2047, 0, ST_OK,       0,    0);     // ignored kind
    add_row(REQ_CANCEL, 600,  0,    1, ST_OK,       600,  640);
    add_row(REQ_CANCEL, 600,  0,    1, ST_NOTFOUND, 600,  0);
    add_row(REQ_CANCEL, 2047, 0,    1, ST_NOTFOUND, 2047, 0);
    add_row(REQ_CANCEL, 0,    0,    1, ST_OK,       0,    15);
    add_row(REQ_LIST,   0,    0,    0, ST_OK,       0,    0);
    foreach (dir_rows[i])
      send_req(dir_rows[i].kind, dir_rows[i].start_min, dir_rows[i].length_min,
               dir_rows[i].typed, dir_rows[i].answer);

    // random phases across bound settings
    wait_idle();
    set_bounds(0, 1440);
    random_batch(16);
    fill_table();
    wait_idle();
    set_bounds(100, 50);
    random_batch(8);
    wait_idle();
    set_bounds(0, 2047);
    random_batch(14);
    wait_idle();
    set_bounds(1, 1);
    random_batch(10);
    wait_idle();
    set_bounds(30, 300);
    random_batch(12);
    wait_idle();
    set_bounds(15, 60);
    random_batch(10);
    wait_idle();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
